FILE: rtl/core/dsfhp_pkg.sv
// Shared types and constants for the DAC sample FIFO with hold and pan.
`timescale 1ns / 1ps
`default_nettype none
package dsfhp_pkg;

  localparam int FIFO_DEPTH   = 2048;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int LVL_W        = PTR_W + 1;
  localparam int DAC_OFF_FILL = 64;
  localparam int CNT_W        = (PTR_W > 7) ? PTR_W : 7;

  localparam int          PAN_LEFT_BIT  = 7;
  localparam int          PAN_RIGHT_BIT = 6;
  localparam logic [7:0]  PAN_RESET     = 8'hC0;
  localparam logic [7:0]  SIGN_FLIP     = 8'h80;

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_TICK    = 3'd1,
    FN_PAN     = 3'd2,
    FN_DAC     = 3'd3,
    FN_PREFILL = 3'd4,
    FN_CLEAR   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  sample_byte;
    logic [7:0]  pan_control;
    logic        dac_on;
    logic [15:0] prefill_count;
    logic        end_of_block;
  } item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               underrun;
    logic               dropped;
    logic [10:0]        fill_level;
    logic [31:0]        underrun_count;
    logic [31:0]        overrun_count;
    logic               block_done;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic pop_load;
    logic fill_step;
    logic fill_done;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic go_pop;
    logic go_fill;
    logic fill_more;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/dsfhp_chan_if.sv
// Valid/ready channel interfaces: command items, results and the config write.
`timescale 1ns / 1ps
`default_nettype none
interface dsfhp_item_if;
  import dsfhp_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dsfhp_result_if;
  import dsfhp_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dsfhp_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dac_sample_fifo_hold_pan.sv
// Top level of the DAC sample FIFO with sample-and-hold and pan gating.
`timescale 1ns / 1ps
`default_nettype none
// Write, pan, DAC on, clear, unused codes, disabled or empty ticks: result registered
// in the cycle after acceptance. Tick that pops: registered read port of the sample
// store, then result register. DAC off / prefill: N zero samples pushed one per cycle
// through the single write port (N up to 64 for DAC off, up to FIFO_DEPTH-1 for
// prefill). One non-pop, non-fill item per clock; input held off while a result stalls.
// Reset (sync, active high): pointers, hold, counters cleared, pan 0xC0, DAC on,
// emulator disabled; store contents are not cleared and there is no clearing pass.
module dac_sample_fifo_hold_pan (
  input  wire logic    clk,
  input  wire logic    rst,
  dsfhp_cfg_if.sink    cfg,
  dsfhp_item_if.sink   cmd,
  dsfhp_result_if.source result
);
  import dsfhp_pkg::*;

  ctl_t  ctl;    // per-cycle commands from the sequencer
  stat_t stat;   // decode and fill status back from the datapath
  logic  in_ready;
  logic  res_valid;

  assign cmd.ready    = in_ready;
  assign result.valid = res_valid;

  // Sequencer: one item in flight; results sit in a register so the
  // next beat can be taken in the same cycle the current result leaves.
  dsfhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_ready (result.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Datapath: ring FIFO store, hold register, pan/DAC gating and counters.
  dsfhp_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (cmd.data),
    .ctl  (ctl),
    .stat (stat),
    .res  (result.data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/dsfhp_ctrl.sv
// Sequencing FSM: accept, registered pop, zero-fill sweep and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module dsfhp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 res_valid,
  input  wire logic            res_ready,
  input  wire dsfhp_pkg::stat_t stat,
  output dsfhp_pkg::ctl_t      ctl
);
  import dsfhp_pkg::*;

  state_t state;
  state_t state_next;
  logic   res_load;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctl.accept) begin
          if (stat.go_pop) begin
            state_next = ST_POP;
          end else if (stat.go_fill) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_POP:  state_next = ST_IDLE;
      ST_FILL: begin
        if (!stat.fill_more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctl           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = !res_valid || res_ready;
        ctl.accept = in_valid && in_ready;
      end
      ST_POP:  ctl.pop_load = 1'b1;
      ST_FILL: begin
        ctl.fill_step = stat.fill_more;
        ctl.fill_done = !stat.fill_more;
      end
      default: ;
    endcase
    res_load = (ctl.accept && !stat.go_pop && !stat.go_fill) || ctl.pop_load || ctl.fill_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dsfhp_dp.sv
// Datapath: sample store, ring pointers, hold/pan state, counters, result register.
`timescale 1ns / 1ps
`default_nettype none
module dsfhp_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  dsfhp_cfg_if.sink              cfg,
  input  wire dsfhp_pkg::item_t  item,
  input  wire dsfhp_pkg::ctl_t   ctl,
  output dsfhp_pkg::stat_t       stat,
  output dsfhp_pkg::result_t     res
);
  import dsfhp_pkg::*;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [LVL_W-1:0] level_of(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
    if (wp >= rp) begin
      return LVL_W'({1'b0, wp}) - LVL_W'({1'b0, rp});
    end
    return LVL_W'(FIFO_DEPTH) + LVL_W'({1'b0, wp}) - LVL_W'({1'b0, rp});
  endfunction

  logic [15:0]      mem [FIFO_DEPTH];
  logic [15:0]      rdata;

  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [15:0]      held, held_next;
  logic             dac_active, dac_active_next;
  logic [7:0]       pan, pan_next;
  logic [31:0]      under_tot, under_tot_next;
  logic [31:0]      over_tot, over_tot_next;
  logic             enable;
  logic [CNT_W-1:0] rem, rem_next;
  logic             eob_q, eob_q_next;

  logic             mem_we;
  logic [15:0]      mem_wdata;
  logic             res_load;
  result_t          res_next;

  logic [LVL_W-1:0] level;
  logic             full;
  logic             empty;
  logic [15:0]      conv;
  logic [CNT_W-1:0] prefill_clamped;
  func_t            op;

  assign cfg.ready = 1'b1;

  assign level = level_of(wr_ptr, rd_ptr);
  assign full  = level >= LVL_W'(FIFO_DEPTH - 1);
  assign empty = level == '0;
  assign conv  = {item.sample_byte ^ SIGN_FLIP, 8'h00};
  assign op    = func_t'(item.func);

  assign prefill_clamped = ({1'b0, item.prefill_count} >= 17'(FIFO_DEPTH)) ?
                           CNT_W'(FIFO_DEPTH - 1) : CNT_W'(item.prefill_count);

  always_comb begin
    stat.go_pop    = (op == FN_TICK) && enable && !empty;
    stat.go_fill   = ((op == FN_DAC) && !item.dac_on) || (op == FN_PREFILL);
    stat.fill_more = !full && (rem != '0);
  end

  always_comb begin
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    held_next       = held;
    dac_active_next = dac_active;
    pan_next        = pan;
    under_tot_next  = under_tot;
    over_tot_next   = over_tot;
    rem_next        = rem;
    eob_q_next      = eob_q;
    mem_we          = 1'b0;
    mem_wdata       = '0;
    res_load        = 1'b0;
    res_next        = '0;

    if (ctl.accept) begin
      res_load   = !stat.go_pop && !stat.go_fill;
      eob_q_next = item.end_of_block;
      unique case (op)
        FN_WRITE: begin
          if (enable) begin
            held_next = conv;
            if (full) begin
              over_tot_next    = over_tot + 32'd1;
              res_next.dropped = 1'b1;
            end else begin
              mem_we      = 1'b1;
              mem_wdata   = conv;
              wr_ptr_next = ptr_adv(wr_ptr);
            end
          end
        end
        FN_TICK: begin
          res_next.block_done = item.end_of_block;
          if (stat.go_pop) begin
            rd_ptr_next = ptr_adv(rd_ptr);
          end else if (enable) begin
            // empty: repeat the held sample
            under_tot_next    = under_tot + 32'd1;
            res_next.underrun = 1'b1;
            if (dac_active && pan[PAN_LEFT_BIT]) begin
              res_next.left_sample = $signed(held);
            end
            if (dac_active && pan[PAN_RIGHT_BIT]) begin
              res_next.right_sample = $signed(held);
            end
          end
        end
        FN_PAN:  pan_next = item.pan_control;
        FN_DAC: begin
          dac_active_next = item.dac_on;
          if (!item.dac_on) begin
            rem_next = CNT_W'(DAC_OFF_FILL);
          end
        end
        FN_PREFILL: rem_next = prefill_clamped;
        FN_CLEAR: begin
          under_tot_next = '0;
          over_tot_next  = '0;
        end
        default: ;
      endcase
    end else if (ctl.pop_load) begin
      held_next           = rdata;
      res_load            = 1'b1;
      res_next.block_done = eob_q;
      if (dac_active && pan[PAN_LEFT_BIT]) begin
        res_next.left_sample = $signed(rdata);
      end
      if (dac_active && pan[PAN_RIGHT_BIT]) begin
        res_next.right_sample = $signed(rdata);
      end
    end else if (ctl.fill_step) begin
      mem_we      = 1'b1;
      wr_ptr_next = ptr_adv(wr_ptr);
      rem_next    = rem - 1'b1;
    end else if (ctl.fill_done) begin
      res_load = 1'b1;
    end

    res_next.fill_level     = 11'(level_of(wr_ptr_next, rd_ptr_next));
    res_next.underrun_count = under_tot_next;
    res_next.overrun_count  = over_tot_next;
  end

  // store: one write port, one registered read port at the read pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= mem_wdata;
    end
    rdata <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      held       <= '0;
      dac_active <= 1'b1;
      pan        <= PAN_RESET;
      under_tot  <= '0;
      over_tot   <= '0;
      enable     <= 1'b0;
      rem        <= '0;
    end else begin
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= rd_ptr_next;
      held       <= held_next;
      dac_active <= dac_active_next;
      pan        <= pan_next;
      under_tot  <= under_tot_next;
      over_tot   <= over_tot_next;
      rem        <= rem_next;
      if (cfg.valid) begin
        enable <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    eob_q <= eob_q_next;
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dsfhp_checker.sv
// Port-level checks for the DAC sample FIFO top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module dsfhp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire dsfhp_pkg::result_t res_data
);
  import dsfhp_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_data))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.underrun && res_data.dropped))
    else $error("underrun and drop flagged on one result");

  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !(in_valid && in_ready))
    else $error("input beat taken while a result is stalled");

endmodule

bind dac_sample_fifo_hold_pan dsfhp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
`default_nettype wire
